// ----- hdl/tbt_pkg.sv -----
// ----------------------------------------------------------------------------
// tbt_pkg: shared types and constants for the transmit opportunity tracker
// Holds the frame type codes, register indexes and the structs that travel
// between the configuration block, the accounting engine and the top level.
// ----------------------------------------------------------------------------
package tbt_pkg;

    localparam int TimeW   = 16;
    localparam int IfsW    = 10;
    localparam int AddrW   = 48;
    localparam int ExchW   = 18;
    localparam int BudgetW = 18;
    localparam int CmdW    = 2;
    localparam int RegIdxW = 2;
    localparam int CfgDataW = 16;

    localparam int InDataW  = 152;  // 146 bits of fields, padded to whole bytes
    localparam int OutDataW = 24;   // 20 bits of fields, padded to whole bytes

    localparam logic [ExchW-1:0] ExchMax = '1;
    localparam logic [IfsW-1:0]  SifsReset = 10'd16;
    localparam logic [IfsW-1:0]  AckReset  = 10'd44;

    // Frame type codes; code 3 is treated as unknown like code 2.
    typedef enum logic [CmdW-1:0] {
        CMD_DATA    = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_UNKNOWN = 2'd2
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [RegIdxW-1:0] {
        REG_TXOP_LIMIT      = 2'd0,
        REG_SIFS_TIME       = 2'd1,
        REG_ACK_TIME        = 2'd2,
        REG_SINGLE_RECEIVER = 2'd3
    } reg_idx_t;

    // Live configuration plus the budget clear that a limit write causes.
    typedef struct packed {
        logic [TimeW-1:0] txop_limit;
        logic [IfsW-1:0]  sifs_time;
        logic [IfsW-1:0]  ack_time;
        logic             single_receiver;
        logic             limit_write;
    } cfg_t;

    // One input request.
    typedef struct packed {
        logic [CmdW-1:0]  cmd;
        logic [TimeW-1:0] frame_time;
        logic [AddrW-1:0] receiver_addr;
        logic [TimeW-1:0] next_time;
        logic [AddrW-1:0] next_receiver_addr;
        logic [ExchW-1:0] exchange_in;
    } item_t;

    // One result request.
    typedef struct packed {
        logic             continued;
        logic             closed;
        logic [ExchW-1:0] exchange_out;
        logic             bad_type;
    } result_t;

endpackage

// ----- hdl/tbt_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tbt_cfg_regs: configuration register file
// Write-only registers for the limit, interframe space, ack time and the
// single-receiver mode. A limit write is flagged in the cycle of the write,
// so the budget clears at the same edge as the new limit is stored.
// ----------------------------------------------------------------------------
module tbt_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tbt_pkg::RegIdxW-1:0]   cfg_addr,
    input  logic [tbt_pkg::CfgDataW-1:0]  cfg_wdata,
    output tbt_pkg::cfg_t                 cfg
);
    import tbt_pkg::*;

    logic [TimeW-1:0] limit_reg;
    logic [IfsW-1:0]  sifs_reg;
    logic [IfsW-1:0]  ack_reg;
    logic             single_reg;

    // Register writes, decoded by index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg    <= '0;
            sifs_reg     <= SifsReset;
            ack_reg      <= AckReset;
            single_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (reg_idx_t'(cfg_addr))
                    REG_TXOP_LIMIT:      limit_reg  <= cfg_wdata[TimeW-1:0];
                    REG_SIFS_TIME:       sifs_reg   <= cfg_wdata[IfsW-1:0];
                    REG_ACK_TIME:        ack_reg    <= cfg_wdata[IfsW-1:0];
                    REG_SINGLE_RECEIVER: single_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    assign cfg.txop_limit      = limit_reg;
    assign cfg.sifs_time       = sifs_reg;
    assign cfg.ack_time        = ack_reg;
    assign cfg.single_receiver = single_reg;
    assign cfg.limit_write     = cfg_we && (reg_idx_t'(cfg_addr) == REG_TXOP_LIMIT);

endmodule

// ----- hdl/tbt_engine.sv -----
// ----------------------------------------------------------------------------
// tbt_engine: opportunity accounting
// Computes the result of one registered request and keeps the remaining
// budget and the latched receiver, updated when the request is consumed.
// ----------------------------------------------------------------------------
module tbt_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tbt_pkg::cfg_t                 cfg,
    input  tbt_pkg::item_t                item,
    input  logic                          fire,
    output tbt_pkg::result_t              result,
    output logic [tbt_pkg::BudgetW-1:0]   budget
);
    import tbt_pkg::*;

    logic [BudgetW-1:0] budget_reg, budget_next;
    logic [AddrW-1:0]   held_reg, held_next;

    logic               is_data;
    logic               opening;
    logic [BudgetW-1:0] budget_start;
    logic [BudgetW-1:0] cost;
    logic [BudgetW-1:0] next_ex;
    logic [BudgetW-1:0] budget_left;
    logic [AddrW-1:0]   held_eff;
    logic               spent;
    logic               closing;
    logic [ExchW:0]     exch_sum;
    logic [ExchW-1:0]   exch_grown;

    // Budget arithmetic for a data frame.
    always_comb begin
        is_data      = (item.cmd == CMD_DATA);
        opening      = (budget_reg == '0);
        budget_start = opening ? {{(BudgetW-TimeW){1'b0}}, cfg.txop_limit} : budget_reg;
        cost         = {{(BudgetW-TimeW){1'b0}}, item.frame_time}
                     + {{(BudgetW-IfsW){1'b0}}, cfg.sifs_time}
                     + {{(BudgetW-IfsW){1'b0}}, cfg.ack_time};
        next_ex      = {{(BudgetW-IfsW-1){1'b0}}, cfg.sifs_time, 1'b0}
                     + {{(BudgetW-TimeW){1'b0}}, item.next_time}
                     + {{(BudgetW-IfsW){1'b0}}, cfg.ack_time};
        budget_left  = budget_start - cost;
        held_eff     = (opening && cfg.single_receiver) ? item.receiver_addr : held_reg;
        spent        = (budget_start <= cost);
        closing      = spent
                     || (item.next_time == '0)
                     || (cfg.single_receiver && (held_eff != item.next_receiver_addr))
                     || (budget_left < next_ex);
        exch_sum     = {1'b0, item.exchange_in} + {1'b0, next_ex[ExchW-1:0]};
        exch_grown   = exch_sum[ExchW] ? ExchMax : exch_sum[ExchW-1:0];
    end

    // Result fields by frame type.
    always_comb begin
        result.continued    = 1'b0;
        result.closed       = 1'b0;
        result.exchange_out = item.exchange_in;
        result.bad_type     = 1'b0;
        unique case (cmd_t'(item.cmd))
            CMD_DATA: begin
                result.continued = !opening;
                result.closed    = closing;
                if (!closing) begin
                    result.exchange_out = exch_grown;
                end
            end
            CMD_ACK: ;
            default: result.bad_type = 1'b1;
        endcase
    end

    // Next state: a limit write clears the budget, else a closing frame empties it.
    always_comb begin
        budget_next = budget_reg;
        held_next   = held_reg;
        if (cfg.limit_write) begin
            budget_next = '0;
        end else if (fire && is_data) begin
            budget_next = closing ? '0 : budget_left;
            if (opening && cfg.single_receiver) begin
                held_next = item.receiver_addr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg <= '0;
            held_reg   <= '0;
        end else begin
            budget_reg <= budget_next;
            held_reg   <= held_next;
        end
    end

    assign budget = budget_reg;

endmodule

// ----- hdl/txop_budget_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// txop_budget_tracker_unit: transmit opportunity budget tracker
// Registers each frame request, runs the budget accounting on it and holds
// the result in an output register until the downstream side takes it.
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+------------------------------
//   s_       | in        | s_tvalid/s_tready | s_tdata frame, s_tuser cmd
//   m_       | out       | m_tvalid/m_tready | m_tdata result, m_tuser bad
//   cfg_     | in        | cfg_we            | cfg_addr, cfg_wdata
//
// A request is held in the input register and its result in the result
// register; one request per cycle is sustained while the output does not
// stall. The budget and receiver registers are updated as a request leaves
// the input register, so the next request sees them at once.
// Reset is synchronous; no clearing pass is needed. A stalled output holds
// its result while the input register still accepts one more request.
// ----------------------------------------------------------------------------
module txop_budget_tracker_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // frame_time, receiver_addr, next_time, next_receiver_addr, exchange_in
    input  logic [tbt_pkg::InDataW-1:0]   s_tdata,
    // cmd
    input  logic [tbt_pkg::CmdW-1:0]      s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // continued, closed, exchange_out
    output logic [tbt_pkg::OutDataW-1:0]  m_tdata,
    // bad_type
    output logic                          m_tuser,
    input  logic                          cfg_we,
    input  logic [tbt_pkg::RegIdxW-1:0]   cfg_addr,
    input  logic [tbt_pkg::CfgDataW-1:0]  cfg_wdata
);
    import tbt_pkg::*;

    cfg_t               cfg;
    item_t              in_reg;
    logic               in_valid_reg;
    result_t            result;
    result_t            out_reg;
    logic               out_valid_reg;
    logic               advance;
    logic [BudgetW-1:0] budget;

    tbt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tbt_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (in_reg),
        .fire    (advance),
        .result  (result),
        .budget  (budget)
    );

    // The input register moves on whenever the output register is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.cmd                <= s_tuser;
            in_reg.frame_time         <= s_tdata[15:0];
            in_reg.receiver_addr      <= s_tdata[63:16];
            in_reg.next_time          <= s_tdata[79:64];
            in_reg.next_receiver_addr <= s_tdata[127:80];
            in_reg.exchange_in        <= s_tdata[145:128];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataW-ExchW-2){1'b0}}, out_reg.exchange_out,
                       out_reg.closed, out_reg.continued};
    assign m_tuser  = out_reg.bad_type;

`ifndef SYNTH
    // An unknown frame never touches the opportunity.
    a_bad_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.bad_type) |-> (!out_reg.closed && !out_reg.continued))
        else $error("unknown frame reported as part of an opportunity");

    // A closing data frame leaves an empty budget.
    a_close_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_reg.cmd == CMD_DATA) && result.closed) |=> (budget == '0))
        else $error("budget not cleared after close");

    // The budget never exceeds the configured limit.
    a_budget_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        budget <= {{(BudgetW-TimeW){1'b0}}, cfg.txop_limit})
        else $error("budget above limit");

    // A frame that opens an opportunity is not a continuation.
    a_open_not_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (budget == '0)) |=> !out_reg.continued)
        else $error("opening frame marked as continuation");
`endif

endmodule
